// ===== rtl/trts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trts_pkg
// Shared types, codes and the note reload table of the tone sequencer.
// ----------------------------------------------------------------------------
package trts_pkg;

    localparam int SONG_DEPTH = 64;
    localparam int NOTE_COUNT = 37;
    localparam int ROM_SIZE   = 37;
    localparam int SONG_AW    = $clog2(SONG_DEPTH);
    localparam int POS_W      = $clog2(SONG_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS       = 2'd2;

    localparam logic [15:0] TICKS_PER_MS_RESET = 16'd1000;
    localparam logic [7:0]  UNIT_MS_RESET      = 8'd62;
    localparam logic [7:0]  GAP_MS_RESET       = 8'd5;
    localparam logic [15:0] TONE_RESET         = 16'd64536;
    localparam logic [15:0] TONE_WRAP          = 16'hFFFF;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NOTE = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] entry_index;
        logic [5:0] entry_note;
        logic [7:0] entry_duration;
        logic       entry_is_end;
    } t_in_item;

    typedef struct packed {
        logic       buzzer_level;
        logic       sounding;
        logic [5:0] current_note_out;
        logic       finished;
    } t_out_item;

    typedef struct packed {
        logic       is_end;
        logic [7:0] duration;
        logic [5:0] note;
    } t_song_entry;

    typedef struct packed {
        logic [15:0] ticks_per_ms;
        logic [7:0]  unit_ms;
        logic [7:0]  gap_ms;
    } t_cfg;

    // Timer reload value per note; zero marks a rest.
    function automatic logic [15:0] reload_of(input logic [5:0] note);
        logic [15:0] val;
        case (note)
            6'd1:  val = 16'd63628;
            6'd2:  val = 16'd63731;
            6'd3:  val = 16'd63835;
            6'd4:  val = 16'd63928;
            6'd5:  val = 16'd64021;
            6'd6:  val = 16'd64103;
            6'd7:  val = 16'd64185;
            6'd8:  val = 16'd64260;
            6'd9:  val = 16'd64331;
            6'd10: val = 16'd64400;
            6'd11: val = 16'd64463;
            6'd12: val = 16'd64528;
            6'd13: val = 16'd64580;
            6'd14: val = 16'd64633;
            6'd15: val = 16'd64684;
            6'd16: val = 16'd64732;
            6'd17: val = 16'd64777;
            6'd18: val = 16'd64820;
            6'd19: val = 16'd64860;
            6'd20: val = 16'd64898;
            6'd21: val = 16'd64934;
            6'd22: val = 16'd64968;
            6'd23: val = 16'd65000;
            6'd24: val = 16'd65030;
            6'd25: val = 16'd65058;
            6'd26: val = 16'd65085;
            6'd27: val = 16'd65110;
            6'd28: val = 16'd65134;
            6'd29: val = 16'd65157;
            6'd30: val = 16'd65178;
            6'd31: val = 16'd65198;
            6'd32: val = 16'd65217;
            6'd33: val = 16'd65235;
            6'd34: val = 16'd65252;
            6'd35: val = 16'd65268;
            6'd36: val = 16'd65283;
            default: val = 16'd0;
        endcase
        if (32'(note) >= NOTE_COUNT || 32'(note) >= ROM_SIZE) begin
            val = 16'd0;
        end
        return val;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/trts_song_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trts_song_ram
// Song memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module trts_song_ram
    import trts_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [SONG_AW-1:0]  i_waddr,
    input  wire t_song_entry         i_wdata,
    input  wire logic                i_re,
    input  wire logic [SONG_AW-1:0]  i_raddr,
    output t_song_entry              o_rdata
);

    t_song_entry r_mem [SONG_DEPTH];
    t_song_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so a stalled item keeps its entry.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/trts_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trts_core
// Playback state: tone counter, millisecond pacing, phase and song position.
// ----------------------------------------------------------------------------
module trts_core
    import trts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_exec,
    input  wire logic [1:0]        i_op,
    input  wire t_song_entry       i_entry,
    input  wire t_cfg              i_cfg,
    output t_out_item              o_status,
    output logic [POS_W-1:0]       o_next_pos
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_tone, n_tone;
    logic             r_buzz, n_buzz;
    logic [15:0]      r_pre, n_pre;
    logic [15:0]      r_rem, n_rem;
    logic [1:0]       r_phase, n_phase;
    logic [5:0]       r_note, n_note;

    always_comb begin
        logic        ms_done;
        logic        phase_end;
        logic        do_load;
        logic [15:0] reload;

        n_pos   = r_pos;
        n_tone  = r_tone;
        n_buzz  = r_buzz;
        n_pre   = r_pre;
        n_rem   = r_rem;
        n_phase = r_phase;
        n_note  = r_note;
        do_load = 1'b0;
        reload  = reload_of(r_note);

        // Prescaler wraps on this tick: one millisecond has gone by.
        ms_done = ({1'b0, r_pre} + 17'd1) >= {1'b0, i_cfg.ticks_per_ms};
        phase_end = 1'b0;

        if (i_exec) begin
            case (i_op)
                OP_TICK: begin
                    if (r_phase == PH_NOTE) begin
                        if (r_rem == 16'd0) begin
                            phase_end = 1'b1;
                        end else begin
                            if (r_tone == TONE_WRAP) begin
                                if (reload != 16'd0) begin
                                    n_tone = reload;
                                    n_buzz = ~r_buzz;
                                end else begin
                                    n_tone = 16'd0;
                                end
                            end else begin
                                n_tone = r_tone + 16'd1;
                            end
                            if (ms_done) begin
                                n_pre = 16'd0;
                                n_rem = r_rem - 16'd1;
                                phase_end = (r_rem == 16'd1);
                            end else begin
                                n_pre = r_pre + 16'd1;
                            end
                        end
                        if (phase_end) begin
                            n_rem   = {8'd0, i_cfg.gap_ms};
                            n_pre   = 16'd0;
                            n_phase = PH_GAP;
                        end
                    end else if (r_phase == PH_GAP) begin
                        if (r_rem == 16'd0) begin
                            do_load = 1'b1;
                        end else if (ms_done) begin
                            n_pre = 16'd0;
                            n_rem = r_rem - 16'd1;
                            do_load = (r_rem == 16'd1);
                        end else begin
                            n_pre = r_pre + 16'd1;
                        end
                        if (do_load) begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                end
                OP_START: begin
                    n_pos   = '0;
                    do_load = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // The entry was fetched at the address this item's load targets.
        if (do_load) begin
            if (32'(n_pos) >= SONG_DEPTH || i_entry.is_end) begin
                n_phase = PH_DONE;
            end else begin
                n_note  = i_entry.note;
                n_rem   = {8'd0, i_cfg.unit_ms} * {8'd0, i_entry.duration};
                n_pre   = 16'd0;
                n_phase = PH_NOTE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_tone  <= TONE_RESET;
            r_buzz  <= 1'b0;
            r_pre   <= 16'd0;
            r_rem   <= 16'd0;
            r_phase <= PH_IDLE;
            r_note  <= 6'd0;
        end else begin
            r_pos   <= n_pos;
            r_tone  <= n_tone;
            r_buzz  <= n_buzz;
            r_pre   <= n_pre;
            r_rem   <= n_rem;
            r_phase <= n_phase;
            r_note  <= n_note;
        end
    end

    assign o_status.buzzer_level     = n_buzz;
    assign o_status.sounding         = (n_phase == PH_NOTE);
    assign o_status.current_note_out = n_note;
    assign o_status.finished         = (n_phase == PH_DONE);
    assign o_next_pos                = n_pos;

endmodule
`default_nettype wire

// ===== rtl/timer_reload_tone_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer_reload_tone_sequencer
// Buzzer song player: song RAM, playback state and result register.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
//   output    out        o_out_valid / i_out_stall o_out_data (t_out_item)
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One transaction per cycle is accepted while o_in_stall is low. The song RAM
// is read into the read stage when a transaction is accepted; the state update
// happens as the item leaves the read stage and also loads the result register.
// Reset is synchronous and active low. An output stall holds the result
// register; one more transaction is taken into the read stage before the input
// channel stalls.
// ----------------------------------------------------------------------------
module timer_reload_tone_sequencer
    import trts_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic             r_s1_valid;
    logic [1:0]       r_s1_op;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             w_accept;
    logic             w_s1_move;
    logic             w_we;
    logic [SONG_AW-1:0] w_raddr;
    t_song_entry      w_wdata;
    t_song_entry      w_rdata;
    t_out_item        w_status;
    logic [POS_W-1:0] w_next_pos;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_move;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_we = w_accept && (i_in_data.opcode == OP_WRITE)
                  && (32'(i_in_data.entry_index) < SONG_DEPTH);
    assign w_wdata.is_end   = i_in_data.entry_is_end;
    assign w_wdata.duration = i_in_data.entry_duration;
    assign w_wdata.note     = i_in_data.entry_note;

    // The position forwarded from the item being executed this cycle picks the
    // entry that a gap end of the new item will load; a start reads entry 0.
    assign w_raddr = (i_in_data.opcode == OP_START) ? '0
                     : SONG_AW'(w_next_pos + POS_W'(1));

    trts_song_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (SONG_AW'(i_in_data.entry_index)),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    trts_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_exec     (w_s1_move),
        .i_op       (r_s1_op),
        .i_entry    (w_rdata),
        .i_cfg      (r_cfg),
        .o_status   (w_status),
        .o_next_pos (w_next_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_ms <= TICKS_PER_MS_RESET;
            r_cfg.unit_ms      <= UNIT_MS_RESET;
            r_cfg.gap_ms       <= GAP_MS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TICKS_PER_MS: r_cfg.ticks_per_ms <= i_cfg_data;
                CFG_UNIT_MS:      r_cfg.unit_ms      <= i_cfg_data[7:0];
                CFG_GAP_MS:       r_cfg.gap_ms       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= w_accept || (r_s1_valid && !w_s1_move);
            r_out_valid <= w_s1_move || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op <= i_in_data.opcode;
        end
        if (w_s1_move) begin
            r_out_data <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with an empty read stage");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_s1_move)
        else $error("stalled result overwritten");

    a_held_item_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_move) |=> (r_s1_valid && $stable(r_s1_op)))
        else $error("waiting item lost from read stage");

    a_phase_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.sounding && o_out_data.finished))
        else $error("result both sounding and finished");
`endif

endmodule
`default_nettype wire
